/* hw/rtl/qrs_pkg.sv */
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants of the quadratic root solver.
// ----------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

    // Default coefficient width (signed Q.8)
    localparam int COEF_WIDTH_DEF = 16;
    // Root format is signed Q16.16
    localparam int ROOT_WIDTH = 32;
    // Quotient scale: num(Q.8) * 2^15 / a gives num / (2a) in Q.16
    localparam int FRAC_SHIFT = 15;
    // Queue depths between the parts
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    localparam logic [ROOT_WIDTH-1:0] ROOT_MAX = 32'h7FFF_FFFF;
    localparam logic [ROOT_WIDTH-1:0] ROOT_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_ONE   = 2'd1,
        KIND_TWO   = 2'd2,
        KIND_DEGEN = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                 kind;
        logic [ROOT_WIDTH-1:0] plus;
        logic [ROOT_WIDTH-1:0] minus;
        logic                  sat;
    } result_t;

endpackage

`default_nettype wire

/* hw/rtl/qrs_fifo.sv */
// ----------------------------------------------------------------------------
// qrs_fifo
// Small first-in first-out queue with a full/empty handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_fifo
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    // Store a transfer
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/qrs_front.sv */
// ----------------------------------------------------------------------------
// qrs_front
// Accept coefficients, form the exact discriminant and classify the item.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_front
import qrs_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    input  wire logic signed [COEF_WIDTH-1:0]      coef_a,
    input  wire logic signed [COEF_WIDTH-1:0]      coef_b,
    input  wire logic signed [COEF_WIDTH-1:0]      coef_c,
    output logic                                   full,
    output logic                                   q_push,
    output logic [2+(2*COEF_WIDTH+1)+2*COEF_WIDTH-1:0] q_data,
    input  wire logic                              q_full
);

    localparam int W  = COEF_WIDTH;
    localparam int DW = 2 * W + 1;
    localparam int XW = 2 * W + 3;

    logic          en;
    logic          f1_vld_reg;
    logic [W-1:0]  f1_a_reg;
    logic [W-1:0]  f1_b_reg;
    logic [W-1:0]  f1_c_reg;
    logic [W-1:0]  mag_a;
    logic [W-1:0]  mag_b;
    logic [W-1:0]  mag_c;
    logic          f2_vld_reg;
    logic [W-1:0]  f2_a_reg;
    logic [W-1:0]  f2_b_reg;
    logic [2*W-1:0] f2_bb_reg;
    logic [2*W-1:0] f2_ac_reg;
    logic          f2_acneg_reg;
    logic [XW-1:0] disc;
    kind_t         kind;

    assign en   = !q_full;
    assign full = q_full;

    // Magnitudes of the coefficients
    always_comb
    begin
        mag_a = f1_a_reg[W-1] ? (~f1_a_reg + W'(1)) : f1_a_reg;
        mag_b = f1_b_reg[W-1] ? (~f1_b_reg + W'(1)) : f1_b_reg;
        mag_c = f1_c_reg[W-1] ? (~f1_c_reg + W'(1)) : f1_c_reg;
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_vld_reg <= push;
            f2_vld_reg <= f1_vld_reg;
        end
    end

    // Capture coefficients, then the two products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_a_reg     <= coef_a;
            f1_b_reg     <= coef_b;
            f1_c_reg     <= coef_c;
            f2_a_reg     <= f1_a_reg;
            f2_b_reg     <= f1_b_reg;
            f2_bb_reg    <= mag_b * mag_b;
            f2_ac_reg    <= mag_a * mag_c;
            f2_acneg_reg <= f1_a_reg[W-1] ^ f1_c_reg[W-1];
        end
    end

    // Discriminant b*b - 4ac and its class
    always_comb
    begin
        if (f2_acneg_reg)
        begin
            disc = XW'(f2_bb_reg) + XW'({f2_ac_reg, 2'b00});
        end
        else
        begin
            disc = XW'(f2_bb_reg) - XW'({f2_ac_reg, 2'b00});
        end
        priority if (f2_a_reg == '0)
        begin
            kind = KIND_DEGEN;
        end
        else if (disc[XW-1])
        begin
            kind = KIND_NONE;
        end
        else if (disc == '0)
        begin
            kind = KIND_ONE;
        end
        else
        begin
            kind = KIND_TWO;
        end
    end

    assign q_push = f2_vld_reg && en;
    assign q_data = {kind, disc[DW-1:0], f2_a_reg, f2_b_reg};

endmodule

`default_nettype wire

/* hw/rtl/qrs_back.sv */
// ----------------------------------------------------------------------------
// qrs_back
// Pipelined square root and two pipelined dividers, then saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_back
import qrs_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  m_empty,
    input  wire logic [2+(2*COEF_WIDTH+1)+2*COEF_WIDTH-1:0] m_data,
    output logic                                       m_pop,
    output logic                                       r_push,
    output result_t                                    r_data,
    input  wire logic                                  r_full
);

    localparam int W  = COEF_WIDTH;
    localparam int DW = 2 * W + 1;
    localparam int SW = W + 1;
    localparam int NW = W + 3;
    localparam int QW = W + 2 + FRAC_SHIFT;
    localparam int EW = (QW > ROOT_WIDTH + 1) ? QW : ROOT_WIDTH + 1;

    logic          en;
    kind_t         in_kind;
    logic [DW-1:0] in_d;
    logic [W-1:0]  in_a;
    logic [W-1:0]  in_b;

    // Square root stages
    logic [SW:0]      sq_vld_reg;
    kind_t            sq_kind_reg [SW+1];
    logic [W-1:0]     sq_a_reg    [SW+1];
    logic [W-1:0]     sq_b_reg    [SW+1];
    logic [2*SW-1:0]  sq_rad_reg  [SW+1];
    logic [SW+1:0]    sq_rem_reg  [SW+1];
    logic [SW-1:0]    sq_root_reg [SW+1];

    // Numerator stage
    logic          nm_vld_reg;
    kind_t         nm_kind_reg;
    logic [W-1:0]  nm_ua_reg;
    logic          nm_negp_reg;
    logic          nm_negm_reg;
    logic [W+1:0]  nm_magp_reg;
    logic [W+1:0]  nm_magm_reg;
    logic [W-1:0]  ua;
    logic [NW-1:0] neg_b;
    logic [NW-1:0] s_ext;
    logic [NW-1:0] num_p;
    logic [NW-1:0] num_m;

    // Divider stages
    logic [QW:0]   dv_vld_reg;
    kind_t         dv_kind_reg [QW+1];
    logic [W-1:0]  dv_ua_reg   [QW+1];
    logic          dv_negp_reg [QW+1];
    logic          dv_negm_reg [QW+1];
    logic [QW-1:0] dv_xp_reg   [QW+1];
    logic [QW-1:0] dv_xm_reg   [QW+1];
    logic [W-1:0]  dv_rp_reg   [QW+1];
    logic [W-1:0]  dv_rm_reg   [QW+1];

    logic [ROOT_WIDTH:0] fin_p;
    logic [ROOT_WIDTH:0] fin_m;

    // Clip a quotient to signed Q16.16; the top bit is the clip flag
    function automatic logic [ROOT_WIDTH:0] clip_root(input logic [QW-1:0] q, input logic neg);
        logic [EW-1:0] qe;
        logic [ROOT_WIDTH:0] res;
        qe = EW'(q);
        if (!neg)
        begin
            if (qe > EW'(ROOT_MAX))
            begin
                res = {1'b1, ROOT_MAX};
            end
            else
            begin
                res = {1'b0, qe[ROOT_WIDTH-1:0]};
            end
        end
        else
        begin
            if (qe > EW'(ROOT_MIN))
            begin
                res = {1'b1, ROOT_MIN};
            end
            else
            begin
                res = {1'b0, ~qe[ROOT_WIDTH-1:0] + ROOT_WIDTH'(1)};
            end
        end
        return res;
    endfunction

    assign en     = !r_full;
    assign m_pop  = en && !m_empty;
    assign r_push = en && dv_vld_reg[QW];
    assign {in_kind, in_d, in_a, in_b} = m_data;

    // Load the first root stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            sq_vld_reg[0] <= m_pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_kind_reg[0] <= in_kind;
            sq_a_reg[0]    <= in_a;
            sq_b_reg[0]    <= in_b;
            sq_rad_reg[0]  <= (2*SW)'(in_d);
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    // One root bit per stage
    for (genvar i = 0; i < SW; i++)
    begin : g_sq
        logic [SW+3:0] rem_sh;
        logic [SW+3:0] trial;
        logic          ge;

        always_comb
        begin
            rem_sh = {sq_rem_reg[i], sq_rad_reg[i][2*SW-1 -: 2]};
            trial  = (SW+4)'({sq_root_reg[i], 2'b01});
            ge     = (rem_sh >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                sq_vld_reg[i+1] <= sq_vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_kind_reg[i+1] <= sq_kind_reg[i];
                sq_a_reg[i+1]    <= sq_a_reg[i];
                sq_b_reg[i+1]    <= sq_b_reg[i];
                sq_rad_reg[i+1]  <= {sq_rad_reg[i][2*SW-3:0], 2'b00};
                sq_rem_reg[i+1]  <= ge ? (SW+2)'(rem_sh - trial) : (SW+2)'(rem_sh);
                sq_root_reg[i+1] <= {sq_root_reg[i][SW-2:0], ge};
            end
        end
    end

    // Form -b + s and -b - s
    always_comb
    begin
        ua    = sq_a_reg[SW][W-1] ? (~sq_a_reg[SW] + W'(1)) : sq_a_reg[SW];
        neg_b = NW'(0) - NW'(signed'(sq_b_reg[SW]));
        s_ext = (sq_kind_reg[SW] == KIND_TWO) ? NW'(sq_root_reg[SW]) : '0;
        num_p = neg_b + s_ext;
        num_m = neg_b - s_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nm_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            nm_vld_reg <= sq_vld_reg[SW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nm_kind_reg <= sq_kind_reg[SW];
            nm_ua_reg   <= ua;
            nm_negp_reg <= num_p[NW-1] ^ sq_a_reg[SW][W-1];
            nm_negm_reg <= num_m[NW-1] ^ sq_a_reg[SW][W-1];
            nm_magp_reg <= num_p[NW-1] ? (W+2)'(NW'(0) - num_p) : num_p[W+1:0];
            nm_magm_reg <= num_m[NW-1] ? (W+2)'(NW'(0) - num_m) : num_m[W+1:0];
        end
    end

    // Load the first divider stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_vld_reg[0] <= nm_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_kind_reg[0] <= nm_kind_reg;
            dv_ua_reg[0]   <= nm_ua_reg;
            dv_negp_reg[0] <= nm_negp_reg;
            dv_negm_reg[0] <= nm_negm_reg;
            dv_xp_reg[0]   <= {nm_magp_reg, FRAC_SHIFT'(0)};
            dv_xm_reg[0]   <= {nm_magm_reg, FRAC_SHIFT'(0)};
            dv_rp_reg[0]   <= '0;
            dv_rm_reg[0]   <= '0;
        end
    end

    // One quotient bit per stage, both roots side by side
    for (genvar j = 0; j < QW; j++)
    begin : g_dv
        logic [W:0] rp_sh;
        logic [W:0] rm_sh;
        logic       gep;
        logic       gem;

        always_comb
        begin
            rp_sh = {dv_rp_reg[j], dv_xp_reg[j][QW-1]};
            rm_sh = {dv_rm_reg[j], dv_xm_reg[j][QW-1]};
            gep   = (rp_sh >= (W+1)'(dv_ua_reg[j]));
            gem   = (rm_sh >= (W+1)'(dv_ua_reg[j]));
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_vld_reg[j+1] <= dv_vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_kind_reg[j+1] <= dv_kind_reg[j];
                dv_ua_reg[j+1]   <= dv_ua_reg[j];
                dv_negp_reg[j+1] <= dv_negp_reg[j];
                dv_negm_reg[j+1] <= dv_negm_reg[j];
                dv_xp_reg[j+1]   <= {dv_xp_reg[j][QW-2:0], gep};
                dv_xm_reg[j+1]   <= {dv_xm_reg[j][QW-2:0], gem};
                dv_rp_reg[j+1]   <= gep ? W'(rp_sh - (W+1)'(dv_ua_reg[j])) : W'(rp_sh);
                dv_rm_reg[j+1]   <= gem ? W'(rm_sh - (W+1)'(dv_ua_reg[j])) : W'(rm_sh);
            end
        end
    end

    // Clip and select the reported roots
    always_comb
    begin
        fin_p = clip_root(dv_xp_reg[QW], dv_negp_reg[QW]);
        fin_m = clip_root(dv_xm_reg[QW], dv_negm_reg[QW]);
        r_data.kind = dv_kind_reg[QW];
        unique case (dv_kind_reg[QW])
            KIND_ONE:
            begin
                r_data.plus  = fin_p[ROOT_WIDTH-1:0];
                r_data.minus = '0;
                r_data.sat   = fin_p[ROOT_WIDTH];
            end
            KIND_TWO:
            begin
                r_data.plus  = fin_p[ROOT_WIDTH-1:0];
                r_data.minus = fin_m[ROOT_WIDTH-1:0];
                r_data.sat   = fin_p[ROOT_WIDTH] | fin_m[ROOT_WIDTH];
            end
            default:
            begin
                r_data.plus  = '0;
                r_data.minus = '0;
                r_data.sat   = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/quadratic_root_solver.sv */
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c over signed Q.8 coefficients.
// ----------------------------------------------------------------------------
// Takes one coefficient set per cycle and returns one result per cycle in
// order while no full queue holds the flow. An item passes two front stages
// that form b*b - 4ac, the middle queue, a load stage, a pipelined square
// root giving one root bit per stage (COEF_WIDTH + 1 stages), one numerator
// stage, a divider load stage, two pipelined restoring dividers giving one
// quotient bit per stage (COEF_WIDTH + 17 stages), and the output queue.
// Roots are signed Q16.16, truncated toward zero and clipped with the
// saturated flag; a zero a reports kind 3 with zero roots.
`default_nettype none

module quadratic_root_solver
import qrs_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic signed [COEF_WIDTH-1:0] coef_a,
    input  wire logic signed [COEF_WIDTH-1:0] coef_b,
    input  wire logic signed [COEF_WIDTH-1:0] coef_c,
    output logic                              empty,
    input  wire logic                         pop,
    output logic [1:0]                        root_kind,
    output logic signed [ROOT_WIDTH-1:0]      root_plus,
    output logic signed [ROOT_WIDTH-1:0]      root_minus,
    output logic                              saturated
);

    localparam int IW = 2 + (2 * COEF_WIDTH + 1) + 2 * COEF_WIDTH;
    localparam int RW = $bits(result_t);

    logic          mid_push;
    logic [IW-1:0] mid_wdata;
    logic          mid_full;
    logic          mid_pop;
    logic [IW-1:0] mid_rdata;
    logic          mid_empty;
    logic          res_push;
    result_t       res_wdata;
    logic          res_full;
    result_t       res_rdata;

    qrs_front #(.COEF_WIDTH(COEF_WIDTH)) u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .coef_a (coef_a),
        .coef_b (coef_b),
        .coef_c (coef_c),
        .full   (full),
        .q_push (mid_push),
        .q_data (mid_wdata),
        .q_full (mid_full)
    );

    qrs_fifo #(.WIDTH(IW), .DEPTH(MID_DEPTH)) u_mid_q
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (mid_wdata),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    qrs_back #(.COEF_WIDTH(COEF_WIDTH)) u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .m_empty (mid_empty),
        .m_data  (mid_rdata),
        .m_pop   (mid_pop),
        .r_push  (res_push),
        .r_data  (res_wdata),
        .r_full  (res_full)
    );

    qrs_fifo #(.WIDTH(RW), .DEPTH(OUT_DEPTH)) u_out_q
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wdata),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign root_kind  = res_rdata.kind;
    assign root_plus  = res_rdata.plus;
    assign root_minus = res_rdata.minus;
    assign saturated  = res_rdata.sat;

endmodule

`default_nettype wire

/* hw/rtl/qrs_checker.sv */
// ----------------------------------------------------------------------------
// qrs_checker
// Port-level checks of the result queue of the quadratic root solver.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_checker
import qrs_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  empty,
    input wire logic [1:0]            root_kind,
    input wire logic [ROOT_WIDTH-1:0] root_plus,
    input wire logic [ROOT_WIDTH-1:0] root_minus,
    input wire logic                  saturated
);

    // Degenerate and rootless results carry no roots
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (root_kind == KIND_DEGEN || root_kind == KIND_NONE))
        |-> (root_plus == '0 && root_minus == '0 && !saturated))
        else $error("absent roots not zero");

    // A single root leaves the minus slot empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && root_kind == KIND_ONE) |-> (root_minus == '0))
        else $error("single root with minus root set");

    // A clipped result shows a limit value
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && saturated) |->
        (root_plus == ROOT_MAX || root_plus == ROOT_MIN ||
         root_minus == ROOT_MAX || root_minus == ROOT_MIN))
        else $error("saturated without limit value");

    // Nothing waits right after reset
    assert property (@(posedge clk) $rose(rst_n) |-> empty)
        else $error("result queue not empty after reset");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .root_kind  (root_kind),
    .root_plus  (root_plus),
    .root_minus (root_minus),
    .saturated  (saturated)
);

`default_nettype wire
